@@ rtl/core/srts_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package srts_pkg;

    localparam int RECORDS_DEFAULT    = 4;
    localparam int NAME_WORDS_DEFAULT = 16;

    // item selector codes
    localparam logic [1:0] FUNC_RECORD = 2'd0;
    localparam logic [1:0] FUNC_QUERY  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    localparam int INFO_W = 38;

    typedef struct packed {
        logic [1:0]  func;
        logic [63:0] name_chunk;
        logic        chunk_last;
        logic [19:0] student_id;
        logic        program_code;
        logic [16:0] average_fixed;
    } in_beat_t;

    typedef struct packed {
        logic        found;
        logic [5:0]  position;
        logic [19:0] match_id;
        logic        match_program;
        logic [16:0] match_average;
    } out_beat_t;

    // controller to datapath
    typedef struct packed {
        logic take_in;
        logic clear_all;
        logic clear_pend;
        logic start_scan;
        logic advance;
        logic word_next;
        logic set_eq;
        logic start_shift;
        logic shift_next;
        logic sh_rd;
        logic sh_wr;
        logic nw_wr;
        logic commit;
        logic out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic scan_end;
        logic cmp_lt;
        logic cmp_gt;
        logic word_last;
        logic shift_done;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

@@ rtl/core/srts_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module srts_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/core/srts_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module srts_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic [1:0]        in_func,
    input  wire logic              in_last,
    input  wire srts_pkg::status_t sts,
    output logic                   in_ready,
    output srts_pkg::cmd_t         cmd
);

    import srts_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SCAN   = 4'd1;
    localparam logic [3:0] S_CMP_RD = 4'd2;
    localparam logic [3:0] S_CMP_EV = 4'd3;
    localparam logic [3:0] S_SH_CHK = 4'd4;
    localparam logic [3:0] S_SH_RD  = 4'd5;
    localparam logic [3:0] S_SH_WR  = 4'd6;
    localparam logic [3:0] S_NW_RD  = 4'd7;
    localparam logic [3:0] S_NW_WR  = 4'd8;
    localparam logic [3:0] S_Q_RD   = 4'd9;
    localparam logic [3:0] S_Q_OUT  = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       query_reg, query_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            query_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            query_reg <= query_next;
        end
    end

    // sequencing of scan, shift, write and reply
    always_comb
    begin
        state_next = state_reg;
        query_next = query_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take_in = 1'b1;
                    if (in_func == FUNC_CLEAR)
                    begin
                        cmd.clear_all = 1'b1;
                    end
                    else if ((in_func == FUNC_RECORD || in_func == FUNC_QUERY) && in_last)
                    begin
                        if (in_func == FUNC_RECORD && sts.full)
                        begin
                            cmd.clear_pend = 1'b1;
                        end
                        else
                        begin
                            cmd.start_scan = 1'b1;
                            query_next     = (in_func == FUNC_QUERY);
                            state_next     = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                if (sts.scan_end)
                begin
                    if (query_reg)
                    begin
                        state_next = S_Q_RD;
                    end
                    else
                    begin
                        cmd.start_shift = 1'b1;
                        state_next      = S_SH_CHK;
                    end
                end
                else
                begin
                    state_next = S_CMP_RD;
                end
            end
            S_CMP_RD:
            begin
                state_next = S_CMP_EV;
            end
            S_CMP_EV:
            begin
                if (sts.cmp_lt)
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_SCAN;
                end
                else if (sts.cmp_gt)
                begin
                    if (query_reg)
                    begin
                        state_next = S_Q_RD;
                    end
                    else
                    begin
                        cmd.start_shift = 1'b1;
                        state_next      = S_SH_CHK;
                    end
                end
                else if (!sts.word_last)
                begin
                    cmd.word_next = 1'b1;
                    state_next    = S_CMP_RD;
                end
                else if (query_reg)
                begin
                    cmd.set_eq = 1'b1;
                    state_next = S_Q_RD;
                end
                else
                begin
                    // equal names keep arrival order
                    cmd.advance = 1'b1;
                    state_next  = S_SCAN;
                end
            end
            S_SH_CHK:
            begin
                state_next = sts.shift_done ? S_NW_RD : S_SH_RD;
            end
            S_SH_RD:
            begin
                cmd.sh_rd  = 1'b1;
                state_next = S_SH_WR;
            end
            S_SH_WR:
            begin
                cmd.sh_wr = 1'b1;
                if (sts.word_last)
                begin
                    cmd.shift_next = 1'b1;
                    state_next     = S_SH_CHK;
                end
                else
                begin
                    cmd.word_next = 1'b1;
                    state_next    = S_SH_RD;
                end
            end
            S_NW_RD:
            begin
                state_next = S_NW_WR;
            end
            S_NW_WR:
            begin
                cmd.nw_wr = 1'b1;
                if (sts.word_last)
                begin
                    cmd.commit     = 1'b1;
                    cmd.clear_pend = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd.word_next = 1'b1;
                    state_next    = S_NW_RD;
                end
            end
            S_Q_RD:
            begin
                state_next = S_Q_OUT;
            end
            S_Q_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.clear_pend = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/srts_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module srts_dp #(
    parameter int RECORDS    = srts_pkg::RECORDS_DEFAULT,
    parameter int NAME_WORDS = srts_pkg::NAME_WORDS_DEFAULT
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire srts_pkg::in_beat_t  in_data,
    input  wire logic                out_ready,
    input  wire srts_pkg::cmd_t      cmd,
    output srts_pkg::status_t        sts,
    output logic                     out_valid,
    output srts_pkg::out_beat_t      out_data
);

    import srts_pkg::*;

    localparam int WW  = (NAME_WORDS > 1) ? $clog2(NAME_WORDS) : 1;
    localparam int PIW = $clog2(RECORDS);
    localparam int CW  = $clog2(RECORDS + 1);
    localparam int KW  = $clog2(NAME_WORDS + 1);
    localparam int PD  = 1 << WW;
    localparam int ND  = RECORDS << WW;

    logic [CW-1:0]     p_reg, i_reg, cnt_reg;
    logic [WW-1:0]     w_reg;
    logic [KW-1:0]     kidx_reg;
    logic [PD-1:0]     pvalid_reg;
    logic              vmask_reg;
    logic              eq_reg;
    logic [19:0]       id_reg;
    logic              prog_reg;
    logic [16:0]       avg_reg;
    logic              out_valid_reg;
    out_beat_t         out_reg;

    logic [CW-1:0]     im1;
    logic              pend_we;
    logic [63:0]       pend_rdata, pend_word, name_rdata, name_wdata;
    logic [PIW+WW-1:0] name_raddr, name_waddr;
    logic              name_we;
    logic [PIW-1:0]    info_raddr, info_waddr;
    logic [INFO_W-1:0] info_rdata, info_wdata;
    logic              info_we;

    assign im1 = i_reg - 1'b1;

    // pending name buffer
    assign pend_we = cmd.take_in
                     && (in_data.func == FUNC_RECORD || in_data.func == FUNC_QUERY)
                     && (kidx_reg < KW'(NAME_WORDS));

    srts_ram #(.WIDTH(64), .DEPTH(PD)) u_pend (
        .clk   (clk),
        .we    (pend_we),
        .waddr (kidx_reg[WW-1:0]),
        .wdata (in_data.name_chunk),
        .raddr (w_reg),
        .rdata (pend_rdata)
    );

    // chunks never received read as zero
    assign pend_word = vmask_reg ? pend_rdata : 64'd0;

    // name table, entry index above word index
    assign name_raddr = cmd.sh_rd ? {im1[PIW-1:0], w_reg} : {p_reg[PIW-1:0], w_reg};
    assign name_waddr = cmd.sh_wr ? {i_reg[PIW-1:0], w_reg} : {p_reg[PIW-1:0], w_reg};
    assign name_we    = cmd.sh_wr || cmd.nw_wr;
    assign name_wdata = cmd.sh_wr ? name_rdata : pend_word;

    srts_ram #(.WIDTH(64), .DEPTH(ND)) u_name (
        .clk   (clk),
        .we    (name_we),
        .waddr (name_waddr),
        .wdata (name_wdata),
        .raddr (name_raddr),
        .rdata (name_rdata)
    );

    // record data table
    assign info_raddr = cmd.sh_rd ? im1[PIW-1:0] : p_reg[PIW-1:0];
    assign info_waddr = cmd.sh_wr ? i_reg[PIW-1:0] : p_reg[PIW-1:0];
    assign info_we    = cmd.sh_wr || cmd.nw_wr;
    assign info_wdata = cmd.sh_wr ? info_rdata : {id_reg, prog_reg, avg_reg};

    srts_ram #(.WIDTH(INFO_W), .DEPTH(RECORDS)) u_info (
        .clk   (clk),
        .we    (info_we),
        .waddr (info_waddr),
        .wdata (info_wdata),
        .raddr (info_raddr),
        .rdata (info_rdata)
    );

    // status toward the controller
    always_comb
    begin
        sts.full       = (cnt_reg == CW'(RECORDS));
        sts.scan_end   = (p_reg == cnt_reg);
        sts.cmp_lt     = (name_rdata < pend_word);
        sts.cmp_gt     = (name_rdata > pend_word);
        sts.word_last  = (w_reg == WW'(NAME_WORDS - 1));
        sts.shift_done = (i_reg == p_reg);
        sts.out_free   = !out_valid_reg || out_ready;
    end

    // control counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            kidx_reg      <= '0;
            pvalid_reg    <= '0;
            p_reg         <= '0;
            i_reg         <= '0;
            w_reg         <= '0;
            eq_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_all)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.commit)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end

            if (cmd.clear_all || cmd.clear_pend)
            begin
                kidx_reg   <= '0;
                pvalid_reg <= '0;
            end
            else if (pend_we)
            begin
                kidx_reg                       <= kidx_reg + 1'b1;
                pvalid_reg[kidx_reg[WW-1:0]]   <= 1'b1;
            end

            if (cmd.start_scan)
            begin
                p_reg <= '0;
            end
            else if (cmd.advance)
            begin
                p_reg <= p_reg + 1'b1;
            end

            if (cmd.start_scan || cmd.advance || cmd.start_shift || cmd.shift_next)
            begin
                w_reg <= '0;
            end
            else if (cmd.word_next)
            begin
                w_reg <= w_reg + 1'b1;
            end

            if (cmd.start_shift)
            begin
                i_reg <= cnt_reg;
            end
            else if (cmd.shift_next)
            begin
                i_reg <= im1;
            end

            if (cmd.start_scan)
            begin
                eq_reg <= 1'b0;
            end
            else if (cmd.set_eq)
            begin
                eq_reg <= 1'b1;
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        vmask_reg <= pvalid_reg[w_reg];
        if (cmd.take_in)
        begin
            id_reg   <= in_data.student_id;
            prog_reg <= in_data.program_code;
            avg_reg  <= in_data.average_fixed;
        end
        if (cmd.out_load)
        begin
            if (eq_reg)
            begin
                out_reg.found         <= 1'b1;
                out_reg.position      <= 6'(p_reg);
                out_reg.match_id      <= info_rdata[37:18];
                out_reg.match_program <= info_rdata[17];
                out_reg.match_average <= info_rdata[16:0];
            end
            else
            begin
                out_reg <= '0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

@@ rtl/core/sorted_record_table_search.sv @@
// Sorted record table: record name chunks build a name that is inserted, in
// name order and after equal names, into a table of RECORDS entries; a query
// name scans the table in order and returns the first equal entry or not
// found, and a clear beat empties the table. Clear beats and all but the last
// chunk of a name are taken while idle, with no further work. After the last
// chunk of a name, the compare walk visits each entry with a scan step and
// then, per word compared, a name table read and a compare, and the walk ends
// with one more scan step when it runs past the last entry. A record then
// moves each later entry down to make room, one read and one write per word,
// and writes the new name word by word; a query reads its record data and then offers its reply.
// The name table is read one word at a time through a registered read port.
// One beat is worked on at a time; a finished reply sits in an output
// register, and the next query reply, with the input behind it, waits only
// until that one is taken.
`timescale 1ns / 1ps
`default_nettype none

module sorted_record_table_search #(
    parameter int RECORDS    = srts_pkg::RECORDS_DEFAULT,
    parameter int NAME_WORDS = srts_pkg::NAME_WORDS_DEFAULT
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire srts_pkg::in_beat_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output srts_pkg::out_beat_t      out_data
);

    import srts_pkg::*;

    cmd_t    cmd;
    status_t sts;

    srts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_func  (in_data.func),
        .in_last  (in_data.chunk_last),
        .sts      (sts),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    srts_dp #(
        .RECORDS    (RECORDS),
        .NAME_WORDS (NAME_WORDS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import srts_pkg::*;

    localparam int RECS  = RECORDS_DEFAULT;
    localparam int WORDS = NAME_WORDS_DEFAULT;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 3000;

    // selector value with no function
    localparam logic [1:0] FUNC_SPARE = 2'd3;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_beat_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_beat_t out_data;

    sorted_record_table_search DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    // table model
    logic [63:0] tbl_name [RECS][WORDS];
    logic [19:0] tbl_id   [RECS];
    logic        tbl_prog [RECS];
    logic [16:0] tbl_avg  [RECS];
    int          tbl_count;
    logic [63:0] pend_name [WORDS];
    int          pend_idx;

    in_beat_t  beat_queue [$];
    out_beat_t reply_queue [$];
    int        errors;
    int        idle_cycles;
    bit        hold_rx;
    int        hold_cnt;
    bit        pause_tx;
    bit        stim_done;
    int        gap_left;
    int        burst_left;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // -1/0/1 as entry e is below, equal to, above the pending name
    function automatic int order_of(int e);
        for (int w = 0; w < WORDS; w++) begin
            if (tbl_name[e][w] < pend_name[w]) return -1;
            if (tbl_name[e][w] > pend_name[w]) return 1;
        end
        return 0;
    endfunction

    function automatic void reset_pending();
        for (int w = 0; w < WORDS; w++) pend_name[w] = '0;
        pend_idx = 0;
    endfunction

    task automatic apply_beat(input in_beat_t b);
        int p;
        out_beat_t r;
        if (b.func == FUNC_CLEAR) begin
            tbl_count = 0;
            reset_pending();
            return;
        end
        if (b.func != FUNC_RECORD && b.func != FUNC_QUERY) return;
        if (pend_idx < WORDS) begin
            pend_name[pend_idx] = b.name_chunk;
            pend_idx++;
        end
        if (!b.chunk_last) return;
        if (b.func == FUNC_RECORD) begin
            if (tbl_count < RECS) begin
                p = 0;
                while (p < tbl_count && order_of(p) <= 0) p++;
                for (int i = tbl_count; i > p; i--) begin
                    tbl_name[i] = tbl_name[i-1];
                    tbl_id[i]   = tbl_id[i-1];
                    tbl_prog[i] = tbl_prog[i-1];
                    tbl_avg[i]  = tbl_avg[i-1];
                end
                for (int w = 0; w < WORDS; w++) tbl_name[p][w] = pend_name[w];
                tbl_id[p]   = b.student_id;
                tbl_prog[p] = b.program_code;
                tbl_avg[p]  = b.average_fixed;
                tbl_count++;
            end
        end else begin
            p = 0;
            r = '0;
            while (p < tbl_count && order_of(p) < 0) p++;
            if (p < tbl_count && order_of(p) == 0) begin
                r.found = 1'b1;
                r.position = p[5:0];
                r.match_id = tbl_id[p];
                r.match_program = tbl_prog[p];
                r.match_average = tbl_avg[p];
            end
            reply_queue.push_back(r);
        end
        reset_pending();
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // name pool with shared prefixes so equal and near names are common
    logic [63:0] pool [6][3];
    int          pool_len [6];

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic push_beat(input logic [1:0] f, input logic [63:0] c, input bit last);
        in_beat_t b;
        b.func = f;
        b.name_chunk = c;
        b.chunk_last = last;
        b.student_id = 20'($urandom_range(1048575, 0));
        b.program_code = 1'($urandom_range(1, 0));
        b.average_fixed = 17'($urandom_range(131071, 0));
        beat_queue.push_back(b);
    endtask

    task automatic push_name(input logic [1:0] f, input int n);
        int len;
        len = pool_len[n];
        for (int k = 0; k < len; k++)
            push_beat(f, pool[n][k], k == len - 1);
    endtask

    task automatic push_long(input logic [1:0] f, input logic [63:0] c, input int len);
        for (int k = 0; k < len; k++) push_beat(f, c, k == len - 1);
    endtask

    task automatic wait_drained();
        while (beat_queue.size() != 0 || in_valid || reply_queue.size() != 0)
            @(posedge clk);
        repeat (RECS * WORDS * 8) @(posedge clk);
    endtask

    // driver: bursts with random gaps
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_data <= '0;
            gap_left <= 0;
            burst_left <= 0;
        end else if (!in_valid || in_ready) begin
            if (in_valid) apply_beat(in_data);
            if (pause_tx || gap_left > 0 || beat_queue.size() == 0) begin
                in_valid <= 1'b0;
                if (gap_left > 0) gap_left <= gap_left - 1;
            end else begin
                in_valid <= 1'b1;
                in_data <= beat_queue.pop_front();
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(12, 1);
                    gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 0);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // monitor and receiver stall pattern, long hold counted here
    always @(posedge clk or negedge rst_n) begin
        out_beat_t want;
        if (!rst_n) begin
            out_ready <= 1'b0;
            hold_cnt <= 0;
        end else begin
            if (out_valid && out_ready) begin
                if (reply_queue.size() == 0) begin
                    report_mismatch("unexpected reply", 64'(out_data), 64'(0));
                end else begin
                    want = reply_queue.pop_front();
                    if (out_data.found !== want.found)
                        report_mismatch("found", 64'(out_data.found), 64'(want.found));
                    if (out_data.position !== want.position)
                        report_mismatch("position", 64'(out_data.position),
                                        64'(want.position));
                    if (out_data.match_id !== want.match_id)
                        report_mismatch("match_id", 64'(out_data.match_id),
                                        64'(want.match_id));
                    if (out_data.match_program !== want.match_program)
                        report_mismatch("match_program", 64'(out_data.match_program),
                                        64'(want.match_program));
                    if (out_data.match_average !== want.match_average)
                        report_mismatch("match_average", 64'(out_data.match_average),
                                        64'(want.match_average));
                end
            end
            if (hold_rx && hold_cnt < HOLD_CYCLES) begin
                hold_cnt <= hold_cnt + 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= $urandom_range(7, 0) < 5 || stim_done;
            end
        end
    end

    // watchdog on cycles with no beat in either direction
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("sorted_record_table_search test failed");
            $finish;
        end
    end

    initial begin
        int n;
        int f;
        errors = 0;
        hold_rx = 1'b0;
        pause_tx = 1'b0;
        stim_done = 1'b0;
        tbl_count = 0;
        reset_pending();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        for (int i = 0; i < 6; i++) begin
            pool_len[i] = $urandom_range(3, 1);
            for (int k = 0; k < 3; k++) pool[i][k] = rand64();
        end
        pool[1][0] = pool[0][0];
        pool[2][0] = '0;
        pool[3][0] = '1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty query, extremes, duplicates, full table, long names
        push_beat(FUNC_QUERY, '0, 1'b1);
        push_beat(FUNC_RECORD, '1, 1'b1);
        push_beat(FUNC_RECORD, '0, 1'b1);
        push_beat(FUNC_RECORD, 64'h4142_0000_0000_0000, 1'b1);
        beat_queue[$].student_id = '1;
        beat_queue[$].average_fixed = '1;
        beat_queue[$].program_code = 1'b1;
        push_beat(FUNC_RECORD, 64'h4142_0000_0000_0000, 1'b1);
        beat_queue[$].student_id = '0;
        beat_queue[$].average_fixed = '0;
        beat_queue[$].program_code = 1'b0;
        push_beat(FUNC_RECORD, 64'h4141_0000_0000_0000, 1'b1);
        push_beat(FUNC_QUERY, 64'h4142_0000_0000_0000, 1'b1);
        push_beat(FUNC_QUERY, '1, 1'b1);
        push_beat(FUNC_QUERY, '0, 1'b1);
        push_beat(FUNC_QUERY, 64'h4143_0000_0000_0000, 1'b1);
        push_beat(FUNC_CLEAR, '0, 1'b0);
        push_beat(FUNC_QUERY, '1, 1'b1);
        push_beat(FUNC_SPARE, 64'h1234, 1'b1);
        push_long(FUNC_RECORD, 64'h5a5a_5a5a_5a5a_5a5a, WORDS + 3);
        push_beat(FUNC_RECORD, 64'h7700, 1'b0);
        push_beat(FUNC_QUERY, 64'h7700, 1'b1);
        push_long(FUNC_QUERY, 64'h5a5a_5a5a_5a5a_5a5a, WORDS + 1);
        push_long(FUNC_QUERY, 64'h5a5a_5a5a_5a5a_5a5a, WORDS);
        wait_drained();

        // hold the receiver while queries keep coming
        hold_rx = 1'b1;
        for (int i = 0; i < 6; i++) push_beat(FUNC_QUERY, '0, 1'b1);
        while (hold_cnt < HOLD_CYCLES) @(posedge clk);
        hold_rx = 1'b0;
        wait_drained();

        // random: well-formed names from a small pool, plus noise
        for (int i = 0; i < 415; i++) begin
            n = $urandom_range(5, 0);
            f = $urandom_range(99, 0);
            if (f < 45) push_name(FUNC_RECORD, n);
            else if (f < 88) push_name(FUNC_QUERY, n);
            else if (f < 94) push_beat(FUNC_CLEAR, rand64(), 1'($urandom_range(1, 0)));
            else if (f < 97) push_beat(FUNC_SPARE, rand64(), 1'($urandom_range(1, 0)));
            else push_beat(2'($urandom_range(1, 0)), rand64(), 1'b0);
            if (i == 200) begin
                while (beat_queue.size() != 0) @(posedge clk);
                pause_tx = 1'b1;
                while (in_valid || reply_queue.size() != 0) @(posedge clk);
                pause_tx = 1'b0;
            end
        end
        stim_done = 1'b1;
        wait_drained();
        if (errors == 0)
            $display("sorted_record_table_search test passed");
        else
            $display("sorted_record_table_search test failed");
        $finish;
    end
endmodule
